[design/mcpf_pkg.sv]
// ----------------------------------------------------------------------------
// mcpf_pkg
// Shared types and codes of the control packet framer: item codes, packet
// kinds, the command that travels from front to back, and the register set.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpf_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // item codes on the input channel
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // packet kinds
    localparam logic [2:0] KIND_CONNECT     = 3'd0;
    localparam logic [2:0] KIND_PUBLISH     = 3'd1;
    localparam logic [2:0] KIND_SUBSCRIBE   = 3'd2;
    localparam logic [2:0] KIND_UNSUBSCRIBE = 3'd3;
    localparam logic [2:0] KIND_PINGREQ     = 3'd4;
    localparam logic [2:0] KIND_DISCONNECT  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_KEEP_ALIVE = 2'd0;
    localparam logic [1:0] CFG_FLAGS      = 2'd1;
    localparam logic [1:0] CFG_PACKET_ID  = 2'd2;
    localparam logic [1:0] CFG_QOS        = 2'd3;

    localparam logic [15:0] KEEP_ALIVE_RST = 16'd60;
    localparam logic [7:0]  FLAGS_RST      = 8'h02;
    localparam logic [15:0] PACKET_ID_RST  = 16'd1;
    localparam logic [1:0]  QOS_RST        = 2'd0;

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_DATA = 2'd1,
        CMD_ERR  = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [2:0]  kind;
        logic [1:0]  nvm1;    // varint bytes minus one
        logic [4:0]  count;   // bytes this command puts out
        logic        last;    // final byte of the command ends the packet
        logic [7:0]  data;
        logic [15:0] slen;
        logic [27:0] rl;
    } t_cmd;

    typedef struct packed {
        logic [15:0] keep_alive;
        logic [7:0]  flags;
        logic [15:0] packet_id;
        logic [1:0]  qos;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

[design/mcpf_front.sv]
// ----------------------------------------------------------------------------
// mcpf_front
// Accepts begin and data items, tracks the open packet and turns each item
// into one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire                  i_op,
    input  wire  [2:0]           i_packet_kind,
    input  wire  [15:0]          i_string_length,
    input  wire  [27:0]          i_message_length,
    input  wire  [7:0]           i_data_byte,
    output mcpf_pkg::t_cmd       o_cmd,
    output logic                 o_push
);
    import mcpf_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_STR  = 3'b010,
        PH_MSG  = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_kind, n_kind;
    logic [15:0] r_sbl, n_sbl;
    logic [27:0] r_mbl, n_mbl;

    logic        is_pub;
    logic        bad_kind;
    logic        has_str;
    logic [16:0] rl_base;
    logic [28:0] rl_sum;
    logic [1:0]  nvm1;
    logic [4:0]  tail_cnt;
    logic        hdr_end;
    logic [15:0] s_dec;
    logic [27:0] m_dec;
    t_cmd        cmd;

    assign is_pub   = (i_packet_kind == KIND_PUBLISH);
    assign bad_kind = (i_packet_kind > KIND_DISCONNECT);
    assign has_str  = (i_packet_kind <= KIND_UNSUBSCRIBE);

    always_comb begin
        unique case (i_packet_kind)
            KIND_CONNECT:     rl_base = {1'b0, i_string_length} + 17'd12;
            KIND_PUBLISH:     rl_base = {1'b0, i_string_length} + 17'd2;
            KIND_SUBSCRIBE:   rl_base = {1'b0, i_string_length} + 17'd5;
            KIND_UNSUBSCRIBE: rl_base = {1'b0, i_string_length} + 17'd4;
            default:          rl_base = 17'd0;
        endcase
    end

    // bit 28 set means the publish length does not fit a four byte varint
    assign rl_sum = {12'd0, rl_base} + (is_pub ? {1'b0, i_message_length} : 29'd0);

    always_comb begin
        priority if (rl_sum[27:21] != 7'd0) nvm1 = 2'd3;
        else if (rl_sum[20:14] != 7'd0)     nvm1 = 2'd2;
        else if (rl_sum[13:7] != 7'd0)      nvm1 = 2'd1;
        else                                nvm1 = 2'd0;
    end

    always_comb begin
        unique case (i_packet_kind)
            KIND_CONNECT:     tail_cnt = 5'd12;
            KIND_PUBLISH:     tail_cnt = 5'd2;
            KIND_SUBSCRIBE:   tail_cnt = (i_string_length == 16'd0) ? 5'd5 : 5'd4;
            KIND_UNSUBSCRIBE: tail_cnt = 5'd4;
            default:          tail_cnt = 5'd0;
        endcase
    end

    assign hdr_end = !has_str
        || (i_string_length == 16'd0 && (!is_pub || i_message_length == 28'd0));

    assign s_dec = r_sbl - 16'd1;
    assign m_dec = r_mbl - 28'd1;

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_sbl     = r_sbl;
        n_mbl     = r_mbl;
        cmd       = '0;
        cmd.op    = CMD_ERR;
        cmd.count = 5'd1;
        cmd.last  = 1'b1;
        if (i_op == OP_BEGIN) begin
            n_phase = PH_IDLE;
            n_sbl   = 16'd0;
            n_mbl   = 28'd0;
            if (!bad_kind && !(is_pub && rl_sum[28])) begin
                cmd.op    = CMD_HDR;
                cmd.kind  = i_packet_kind;
                cmd.nvm1  = nvm1;
                cmd.count = 5'd2 + {3'd0, nvm1} + tail_cnt;
                cmd.last  = hdr_end;
                cmd.slen  = i_string_length;
                cmd.rl    = rl_sum[27:0];
                n_kind    = i_packet_kind;
                n_sbl     = has_str ? i_string_length : 16'd0;
                n_mbl     = is_pub ? i_message_length : 28'd0;
                if (has_str && i_string_length != 16'd0) begin
                    n_phase = PH_STR;
                end else if (is_pub && i_message_length != 28'd0) begin
                    n_phase = PH_MSG;
                end
            end
        end else begin
            cmd.data = i_data_byte;
            priority if (r_phase == PH_STR && r_sbl != 16'd0) begin
                cmd.op = CMD_DATA;
                n_sbl  = s_dec;
                if (s_dec != 16'd0) begin
                    cmd.last = 1'b0;
                end else if (r_mbl != 28'd0) begin
                    cmd.last = 1'b0;
                    n_phase  = PH_MSG;
                end else begin
                    // subscribe topic is followed by the qos byte
                    if (r_kind == KIND_SUBSCRIBE) cmd.count = 5'd2;
                    n_phase = PH_IDLE;
                end
            end else if (r_phase == PH_MSG && r_mbl != 28'd0) begin
                cmd.op = CMD_DATA;
                n_mbl  = m_dec;
                if (m_dec != 28'd0) begin
                    cmd.last = 1'b0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                cmd.data = 8'd0;
                n_phase  = PH_IDLE;
                n_sbl    = 16'd0;
                n_mbl    = 28'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= 3'd0;
            r_sbl   <= 16'd0;
            r_mbl   <= 28'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_sbl   <= n_sbl;
            r_mbl   <= n_mbl;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept;

    a_str_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STR) |-> (r_sbl != 16'd0))
        else $error("string phase with no string bytes left");

    a_msg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MSG) |-> (r_mbl != 28'd0 && r_sbl == 16'd0))
        else $error("message phase with bad counters");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_sbl == 16'd0 && r_mbl == 28'd0))
        else $error("idle with counters left");

endmodule

`default_nettype wire

[design/mcpf_queue.sv]
// ----------------------------------------------------------------------------
// mcpf_queue
// Short command queue between front and back; the head entry is read in
// place by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mcpf_pkg::t_cmd       i_cmd,
    input  wire                  i_pop,
    output mcpf_pkg::t_cmd       o_head,
    output mcpf_pkg::t_q_status  o_status
);
    import mcpf_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wr_ptr;
    logic [Q_AW:0] r_rd_ptr;
    logic          full;
    logic          empty;

    assign empty = (r_wr_ptr == r_rd_ptr);
    assign full  = (r_wr_ptr[Q_AW] != r_rd_ptr[Q_AW])
                && (r_wr_ptr[Q_AW-1:0] == r_rd_ptr[Q_AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[Q_AW-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
        end
    end

    assign o_head         = r_mem[r_rd_ptr[Q_AW-1:0]];
    assign o_status.full  = full;
    assign o_status.empty = empty;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !empty)
        else $error("pop from empty queue");

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_wr_ptr != r_rd_ptr))
        else $error("queue empty right after a push");

endmodule

`default_nettype wire

[design/mcpf_back.sv]
// ----------------------------------------------------------------------------
// mcpf_back
// Expands queued commands into wire bytes, one per cycle, into an output
// register that holds under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mcpf_pkg::t_cmd       i_head,
    input  mcpf_pkg::t_q_status  i_status,
    input  mcpf_pkg::t_cfg       i_cfg,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_last,
    output logic                 o_error
);
    import mcpf_pkg::*;

    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_T = 8'h54;

    logic [4:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_err;

    logic       advance;
    logic       take;
    logic       at_end;
    logic [4:0] vend;
    logic [1:0] vk;
    logic [3:0] tidx;
    logic [4:0] tsub;
    logic [6:0] vbits;
    logic [7:0] hdr_byte;
    logic [7:0] byte_val;

    function automatic logic [7:0] f_type(input logic [2:0] kind);
        logic [7:0] b;
        unique case (kind)
            KIND_CONNECT:     b = 8'h10;
            KIND_PUBLISH:     b = 8'h30;
            KIND_SUBSCRIBE:   b = 8'h82;
            KIND_UNSUBSCRIBE: b = 8'hA2;
            KIND_PINGREQ:     b = 8'hC0;
            default:          b = 8'hE0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] f_tail(input logic [2:0] kind, input logic [3:0] t,
                                          input t_cfg cfg, input logic [15:0] slen);
        logic [7:0] b;
        b = 8'd0;
        unique case (kind)
            KIND_CONNECT: begin
                unique case (t)
                    4'd0:    b = 8'h00;
                    4'd1:    b = 8'h04;
                    4'd2:    b = CH_M;
                    4'd3:    b = CH_Q;
                    4'd4:    b = CH_T;
                    4'd5:    b = CH_T;
                    4'd6:    b = 8'h04;
                    4'd7:    b = cfg.flags;
                    4'd8:    b = cfg.keep_alive[15:8];
                    4'd9:    b = cfg.keep_alive[7:0];
                    4'd10:   b = slen[15:8];
                    default: b = slen[7:0];
                endcase
            end
            KIND_PUBLISH: begin
                b = (t == 4'd0) ? slen[15:8] : slen[7:0];
            end
            KIND_SUBSCRIBE, KIND_UNSUBSCRIBE: begin
                unique case (t)
                    4'd0:    b = cfg.packet_id[15:8];
                    4'd1:    b = cfg.packet_id[7:0];
                    4'd2:    b = slen[15:8];
                    4'd3:    b = slen[7:0];
                    default: b = {6'd0, cfg.qos};
                endcase
            end
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    assign advance = !r_out_valid || !i_out_stall;
    assign take    = advance && !i_status.empty;
    assign at_end  = (r_idx == i_head.count - 5'd1);
    assign o_pop   = take && at_end;

    // header layout: type byte, varint bytes, then the fixed tail
    assign vend = {3'd0, i_head.nvm1} + 5'd1;
    assign vk   = r_idx[1:0] - 2'd1;
    assign tsub = r_idx - 5'd2 - {3'd0, i_head.nvm1};
    assign tidx = tsub[3:0];

    always_comb begin
        unique case (vk)
            2'd0: vbits = i_head.rl[6:0];
            2'd1: vbits = i_head.rl[13:7];
            2'd2: vbits = i_head.rl[20:14];
            default: vbits = i_head.rl[27:21];
        endcase
    end

    always_comb begin
        priority if (r_idx == 5'd0) begin
            hdr_byte = f_type(i_head.kind);
        end else if (r_idx <= vend) begin
            hdr_byte = {(vk < i_head.nvm1), vbits};
        end else begin
            hdr_byte = f_tail(i_head.kind, tidx, i_cfg, i_head.slen);
        end
    end

    always_comb begin
        unique case (i_head.op)
            CMD_HDR:  byte_val = hdr_byte;
            CMD_DATA: byte_val = (r_idx == 5'd0) ? i_head.data : {6'd0, i_cfg.qos};
            default:  byte_val = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 5'd0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
            r_idx       <= at_end ? 5'd0 : r_idx + 5'd1;
        end else if (advance) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= byte_val;
            r_out_last <= i_head.last && at_end;
            r_out_err  <= (i_head.op == CMD_ERR);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && r_out_byte == 8'd0))
        else $error("error beat not last or not zero");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_status.empty |-> (r_idx < i_head.count))
        else $error("byte index beyond command");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.empty |-> (r_idx == 5'd0))
        else $error("byte index left over with empty queue");

endmodule

`default_nettype wire

[design/mqtt_control_packet_framer_unit.sv]
// ----------------------------------------------------------------------------
// mqtt_control_packet_framer_unit
// MQTT 3.1.1 client packet encoder: begin descriptors and payload bytes in,
// packet bytes out.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | i_in_valid/o_in_stall | i_op, i_packet_kind,
//           |           |                       | i_string_length, i_message_length,
//           |           |                       | i_data_byte
//   out     | output    | o_out_valid/i_out_stall | o_out_byte, o_last, o_error
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a data item is one beat in and one beat out (two for the last subscribe topic byte);
// a begin item gives 1 to 16 header beats, one per cycle from the back end unless stalled
// the front takes one item per cycle until its 4-entry command queue fills
// an item is written to the command queue, then its first beat to the output register
// reset loads register defaults, empties the queue and closes any open packet
// o_out_* hold while o_out_valid and i_out_stall are high; o_cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_control_packet_framer_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire          i_op,
    input  wire  [2:0]   i_packet_kind,
    input  wire  [15:0]  i_string_length,
    input  wire  [27:0]  i_message_length,
    input  wire  [7:0]   i_data_byte,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic [7:0]   o_out_byte,
    output logic         o_last,
    output logic         o_error,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [15:0]  i_cfg_data
);
    import mcpf_pkg::*;

    t_cfg      r_cfg;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic      in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_alive <= KEEP_ALIVE_RST;
            r_cfg.flags      <= FLAGS_RST;
            r_cfg.packet_id  <= PACKET_ID_RST;
            r_cfg.qos        <= QOS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEEP_ALIVE: r_cfg.keep_alive <= i_cfg_data;
                CFG_FLAGS:      r_cfg.flags      <= i_cfg_data[7:0];
                CFG_PACKET_ID:  r_cfg.packet_id  <= i_cfg_data;
                default:        r_cfg.qos        <= i_cfg_data[1:0];
            endcase
        end
    end

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    mcpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_op             (i_op),
        .i_packet_kind    (i_packet_kind),
        .i_string_length  (i_string_length),
        .i_message_length (i_message_length),
        .i_data_byte      (i_data_byte),
        .o_cmd            (push_cmd),
        .o_push           (push)
    );

    mcpf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    mcpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_status    (q_status),
        .i_cfg       (r_cfg),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

`default_nettype wire

[tb/tb_mqtt_control_packet_framer_unit.sv]
// ----------------------------------------------------------------------------
// tb_mqtt_control_packet_framer_unit
// Self-checking bench for the MQTT client packet framer. Begin descriptors and
// payload bytes go in with random gaps, and packet bytes come out under random
// stall. A tracker class builds the expected wire bytes from each accepted
// beat and matches every output beat against them in order. Register settings
// change between runs of traffic once the output has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mqtt_control_packet_framer_unit;

    import mcpf_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          BURST_CAP   = 20;
    localparam int          SEG_ITEMS   = 80;
    localparam logic [28:0] RL_MAX      = 29'd268435455;

    localparam logic [7:0] HDR_CONNECT     = 8'h10;
    localparam logic [7:0] HDR_PUBLISH     = 8'h30;
    localparam logic [7:0] HDR_SUBSCRIBE   = 8'h82;
    localparam logic [7:0] HDR_UNSUBSCRIBE = 8'hA2;
    localparam logic [7:0] HDR_PINGREQ     = 8'hC0;
    localparam logic [7:0] HDR_DISCONNECT  = 8'hE0;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_STRING  = 2'd1,
        PH_MESSAGE = 2'd2
    } frame_ph_t;

    typedef struct {
        logic        op;
        logic [2:0]  kind;
        logic [15:0] slen;
        logic [27:0] mlen;
        logic [7:0]  data;
    } item_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       err;
    } beat_t;

    class wire_byte_tracker;
        beat_t       wire_bytes_due[$];
        logic [15:0] keep_alive;
        logic [7:0]  flags;
        logic [15:0] packet_id;
        logic [1:0]  qos;
        frame_ph_t   ph;
        logic [2:0]  open_kind;
        logic [15:0] str_left;
        logic [27:0] msg_left;
        int          fails;
        int          beats_in;
        int          begins;
        int          beats_out;
        int          err_beats;
        int          reg_writes;

        function new();
            keep_alive = KEEP_ALIVE_RST;
            flags      = FLAGS_RST;
            packet_id  = PACKET_ID_RST;
            qos        = QOS_RST;
            ph         = PH_IDLE;
            open_kind  = KIND_CONNECT;
            str_left   = '0;
            msg_left   = '0;
            fails      = 0;
            beats_in   = 0;
            begins     = 0;
            beats_out  = 0;
            err_beats  = 0;
            reg_writes = 0;
        endfunction

        // quiet after the first hundred failures, still counted
        function bit note_fail();
            fails++;
            return fails <= 100;
        endfunction

        function void queue_beat(logic [7:0] b, logic l, logic e);
            beat_t x;
            x.b    = b;
            x.last = l;
            x.err  = e;
            wire_bytes_due.push_back(x);
            if (e) err_beats++;
        endfunction

        function void close_packet();
            ph       = PH_IDLE;
            str_left = '0;
            msg_left = '0;
        endfunction

        function void take_reg(logic [1:0] idx, logic [15:0] val);
            reg_writes++;
            case (idx)
                CFG_KEEP_ALIVE: keep_alive = val;
                CFG_FLAGS:      flags      = val[7:0];
                CFG_PACKET_ID:  packet_id  = val;
                default:        qos        = val[1:0];
            endcase
        endfunction

        function void open_packet(logic [2:0] kind, logic [15:0] slen, logic [27:0] mlen);
            logic [7:0]  hdr[$];
            logic [28:0] rl;
            logic [7:0]  vb;
            int          nv;
            close_packet();
            if (kind > KIND_DISCONNECT) begin
                queue_beat(8'h00, 1'b1, 1'b1);
                return;
            end
            rl = 29'd2 + slen + mlen;
            if (kind == KIND_PUBLISH && rl > RL_MAX) begin
                queue_beat(8'h00, 1'b1, 1'b1);
                return;
            end
            case (kind)
                KIND_CONNECT: begin
                    hdr.push_back(HDR_CONNECT);
                    rl = 29'd12 + slen;
                end
                KIND_PUBLISH: hdr.push_back(HDR_PUBLISH);
                KIND_SUBSCRIBE: begin
                    hdr.push_back(HDR_SUBSCRIBE);
                    rl = 29'd5 + slen;
                end
                KIND_UNSUBSCRIBE: begin
                    hdr.push_back(HDR_UNSUBSCRIBE);
                    rl = 29'd4 + slen;
                end
                KIND_PINGREQ: begin
                    hdr.push_back(HDR_PINGREQ);
                    rl = '0;
                end
                default: begin
                    hdr.push_back(HDR_DISCONNECT);
                    rl = '0;
                end
            endcase
            // remaining length, 7 bits per byte, low group first
            nv = 0;
            do begin
                vb = {1'b0, rl[6:0]};
                rl = rl >> 7;
                if (rl != 0) vb[7] = 1'b1;
                hdr.push_back(vb);
                nv++;
            end while (rl != 0 && nv < 4);
            if (kind == KIND_CONNECT) begin
                // protocol name "MQTT" with its length, then level 4
                hdr.push_back(8'h00);
                hdr.push_back(8'h04);
                hdr.push_back(8'h4D);
                hdr.push_back(8'h51);
                hdr.push_back(8'h54);
                hdr.push_back(8'h54);
                hdr.push_back(8'h04);
                hdr.push_back(flags);
                hdr.push_back(keep_alive[15:8]);
                hdr.push_back(keep_alive[7:0]);
            end else if (kind == KIND_SUBSCRIBE || kind == KIND_UNSUBSCRIBE) begin
                hdr.push_back(packet_id[15:8]);
                hdr.push_back(packet_id[7:0]);
            end
            if (kind <= KIND_UNSUBSCRIBE) begin
                hdr.push_back(slen[15:8]);
                hdr.push_back(slen[7:0]);
                str_left = slen;
            end
            if (kind == KIND_PUBLISH) msg_left = mlen;
            if (kind == KIND_SUBSCRIBE && slen == 0) hdr.push_back({6'b0, qos});
            open_kind = kind;
            if (str_left != 0) ph = PH_STRING;
            else if (msg_left != 0) ph = PH_MESSAGE;
            else ph = PH_IDLE;
            foreach (hdr[i])
                queue_beat(hdr[i], (ph == PH_IDLE && i == hdr.size() - 1), 1'b0);
        endfunction

        function void pass_byte(logic [7:0] b);
            if (ph == PH_STRING && str_left != 0) begin
                str_left--;
                if (str_left != 0) begin
                    queue_beat(b, 1'b0, 1'b0);
                end else if (msg_left != 0) begin
                    queue_beat(b, 1'b0, 1'b0);
                    ph = PH_MESSAGE;
                end else if (open_kind == KIND_SUBSCRIBE) begin
                    queue_beat(b, 1'b0, 1'b0);
                    queue_beat({6'b0, qos}, 1'b1, 1'b0);
                    close_packet();
                end else begin
                    queue_beat(b, 1'b1, 1'b0);
                    close_packet();
                end
            end else if (ph == PH_MESSAGE && msg_left != 0) begin
                msg_left--;
                if (msg_left != 0) begin
                    queue_beat(b, 1'b0, 1'b0);
                end else begin
                    queue_beat(b, 1'b1, 1'b0);
                    close_packet();
                end
            end else begin
                close_packet();
                queue_beat(8'h00, 1'b1, 1'b1);
            end
        endfunction

        function void take_item(item_t it);
            beats_in++;
            if (it.op == OP_BEGIN) begin
                begins++;
                open_packet(it.kind, it.slen, it.mlen);
            end else begin
                pass_byte(it.data);
            end
        endfunction

        function void match_beat(logic [7:0] b, logic l, logic e);
            beat_t want;
            beats_out++;
            if (wire_bytes_due.size() == 0) begin
                if (note_fail())
                    $error("unexpected beat: out_byte %02h last %0b error %0b", b, l, e);
                return;
            end
            want = wire_bytes_due.pop_front();
            if (b !== want.b && note_fail())
                $error("out_byte: expected %02h, got %02h", want.b, b);
            if (l !== want.last && note_fail())
                $error("last: expected %0b, got %0b", want.last, l);
            if (e !== want.err && note_fail())
                $error("error: expected %0b, got %0b", want.err, e);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_op;
    logic [2:0]  i_packet_kind;
    logic [15:0] i_string_length;
    logic [27:0] i_message_length;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    wire_byte_tracker sb;
    int               items_sent;
    bit               tx_burst;
    bit               rx_burst;
    bit               hold_req;
    int               rx_wait;

    mqtt_control_packet_framer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_packet_kind   (i_packet_kind),
        .i_string_length (i_string_length),
        .i_message_length(i_message_length),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last),
        .o_error         (o_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // output side: stall for a drawn number of cycles before each beat
    initial begin
        i_out_stall = 1'b0;
        rx_wait     = 0;
        rx_burst    = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            rx_wait  = HOLD_CYCLES;
        end
        if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.match_beat(o_out_byte, o_last, o_error);
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
        end
    end

    function automatic item_t mk_begin(logic [2:0] kind, logic [15:0] slen, logic [27:0] mlen);
        item_t it;
        it.op   = OP_BEGIN;
        it.kind = kind;
        it.slen = slen;
        it.mlen = mlen;
        it.data = 8'($urandom);
        return it;
    endfunction

    function automatic item_t mk_data(logic [7:0] b);
        item_t it;
        it.op   = OP_DATA;
        it.kind = 3'($urandom);
        it.slen = 16'($urandom);
        it.mlen = 28'($urandom);
        it.data = b;
        return it;
    endfunction

    function automatic int payload_len(logic [2:0] kind, logic [15:0] slen, logic [27:0] mlen);
        if (kind > KIND_UNSUBSCRIBE) return 0;
        return int'(slen) + ((kind == KIND_PUBLISH) ? int'(mlen) : 0);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_op             <= it.op;
        i_packet_kind    <= it.kind;
        i_string_length  <= it.slen;
        i_message_length <= it.mlen;
        i_data_byte      <= it.data;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
        items_sent++;
    endtask

    task automatic send_packet(input logic [2:0] kind, input logic [15:0] slen,
                               input logic [27:0] mlen, input int nbytes);
        send_item(mk_begin(kind, slen, mlen));
        repeat (nbytes) send_item(mk_data(8'($urandom)));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.wire_bytes_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.take_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // narrow registers get random junk above their width
    task automatic set_regs(input logic [15:0] ka, input logic [7:0] fl,
                            input logic [15:0] pid, input logic [1:0] q);
        write_reg(CFG_KEEP_ALIVE, ka);
        write_reg(CFG_FLAGS, {8'($urandom), fl});
        write_reg(CFG_PACKET_ID, pid);
        write_reg(CFG_QOS, {14'($urandom), q});
    endtask

    task automatic random_traffic(input int count);
        int          seg_end;
        int          pick;
        int          full;
        int          n;
        int          edge_rl;
        logic [2:0]  kind;
        logic [15:0] slen;
        logic [27:0] mlen;
        seg_end = items_sent + count;
        while (items_sent < seg_end) begin
            pick = $urandom_range(0, 99);
            kind = 3'($urandom_range(0, 5));
            slen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    // land the remaining length on a varint size boundary
                    slen = 16'($urandom_range(0, 8));
                    case ($urandom_range(0, 6))
                        0: edge_rl = 127;
                        1: edge_rl = 128;
                        2: edge_rl = 16383;
                        3: edge_rl = 16384;
                        4: edge_rl = 2097151;
                        5: edge_rl = 2097152;
                        default: edge_rl = 268435455;
                    endcase
                    mlen = 28'(edge_rl - 2 - int'(slen));
                end
                3, 4: mlen = 28'($urandom);
                default: mlen = 28'($urandom_range(0, 10));
            endcase
            full = payload_len(kind, slen, mlen);
            if (pick < 80) begin
                send_packet(kind, slen, mlen, (full > BURST_CAP) ? BURST_CAP : full);
            end else if (pick < 90) begin
                // cut short, or run past the end into unexpected data
                if (full > 0 && full <= BURST_CAP && $urandom_range(0, 1) == 1)
                    n = $urandom_range(0, full - 1);
                else
                    n = ((full > BURST_CAP) ? BURST_CAP : full) + $urandom_range(1, 2);
                send_packet(kind, slen, mlen, n);
            end else if (pick < 95) begin
                send_item(mk_data(8'($urandom)));
            end else begin
                send_item(mk_begin(3'($urandom_range(6, 7)), 16'($urandom), 28'($urandom)));
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_op             = OP_BEGIN;
        i_packet_kind    = KIND_CONNECT;
        i_string_length  = '0;
        i_message_length = '0;
        i_data_byte      = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_KEEP_ALIVE;
        i_cfg_data       = '0;
        items_sent       = 0;
        tx_burst         = 1'b0;
        hold_req         = 1'b0;
        sb               = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register defaults after reset
        send_item(mk_data(8'h00));
        send_item(mk_begin(3'd7, 16'hFFFF, 28'hFFFFFFF));
        send_item(mk_begin(3'd6, 16'h0000, 28'h0000000));
        send_packet(KIND_PINGREQ, 16'd3, 28'd5, 0);
        send_packet(KIND_DISCONNECT, 16'd0, 28'd0, 0);
        send_packet(KIND_CONNECT, 16'd0, 28'd0, 0);
        send_item(mk_begin(KIND_CONNECT, 16'd2, 28'd9));
        send_item(mk_data(8'hFF));
        send_item(mk_data(8'h00));
        send_packet(KIND_PUBLISH, 16'd0, 28'd0, 0);
        send_packet(KIND_PUBLISH, 16'd1, 28'd2, 3);
        // largest legal remaining length, then dropped by the next begin
        send_packet(KIND_PUBLISH, 16'd0, 28'd268435453, 1);
        send_packet(KIND_PUBLISH, 16'hFFFF, 28'hFFFFFFF, 0);
        send_packet(KIND_PUBLISH, 16'd0, 28'd268435454, 0);
        send_packet(KIND_SUBSCRIBE, 16'd0, 28'd7, 0);
        send_packet(KIND_SUBSCRIBE, 16'd1, 28'd0, 1);
        send_packet(KIND_UNSUBSCRIBE, 16'd1, 28'd0, 1);
        send_packet(KIND_CONNECT, 16'hFFFF, 28'd0, 1);
        wait_drain();

        set_regs(16'h0000, 8'h00, 16'h0000, 2'd0);
        random_traffic(SEG_ITEMS);
        wait_drain();

        // all ones, reserved flag bit and qos three included
        set_regs(16'hFFFF, 8'hFF, 16'hFFFF, 2'd3);
        hold_req = 1'b1;
        random_traffic(SEG_ITEMS);
        wait_drain();

        set_regs(16'($urandom), 8'($urandom), 16'($urandom), 2'($urandom_range(0, 2)));
        random_traffic(SEG_ITEMS);
        wait_drain();

        set_regs(16'($urandom), 8'($urandom), 16'($urandom), 2'($urandom_range(0, 3)));
        random_traffic(SEG_ITEMS);
        wait_drain();

        // catch any stray beat after the last expected one
        repeat (24) @(negedge i_clk);
        if (sb.wire_bytes_due.size() != 0) begin
            sb.fails++;
            $error("%0d expected beats never came out", sb.wire_bytes_due.size());
        end

        $display("covered %0d input beats (%0d packet begins) and %0d register writes",
                 sb.beats_in, sb.begins, sb.reg_writes);
        $display("checked %0d output beats, %0d of them error results",
                 sb.beats_out, sb.err_beats);
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
